// ----- rtl/core/gba_pkg.sv -----
// Package for the grid box aggregator: types, codes, constants and helpers.
// No dependencies.
package gba_pkg;

    localparam int DEF_MAX_OUT_COLUMNS = 1024;
    localparam int DEF_MAX_KERNEL      = 16;
    localparam logic [14:0] COLUMN_LIMIT = 15'd16384;

    localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
    localparam logic [1:0] REG_METHOD      = 2'd1;
    localparam logic [1:0] REG_WEIGHT_MODE = 2'd2;
    localparam logic [1:0] REG_IN_COLUMNS  = 2'd3;

    localparam logic [1:0] METH_AVG = 2'd0;
    localparam logic [1:0] METH_MIN = 2'd1;
    localparam logic [1:0] METH_MAX = 2'd2;
    localparam logic [1:0] METH_SUM = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SYNC_COL,
        ST_WAIT_COL,
        ST_SYNC_NB,
        ST_WAIT_NB,
        ST_READ,
        ST_UPDATE,
        ST_PREP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } gba_state_t;

    typedef struct packed {
        logic               seen;
        logic [31:0]        mw;
        logic [31:0]        pw;
        logic signed [63:0] acc;
    } box_entry_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- rtl/core/gba_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module gba_div #(
    parameter int NW = 16,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/gba_box_mem.sv -----
// Per-column box state memory, registered read, with clearing sweep
// after reset. Depends on gba_pkg.
module gba_box_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output gba_pkg::box_entry_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  gba_pkg::box_entry_t wr_data,
    output logic                clear_busy
);
    import gba_pkg::*;

    box_entry_t    mem [DEPTH];
    box_entry_t    rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          clr_busy_reg;
    logic          we;
    logic [AW-1:0] wa;
    box_entry_t    wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        we = clr_busy_reg | wr_en;
        wa = clr_busy_reg ? clr_addr_reg : wr_addr;
        wd = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ----- rtl/core/grid_box_aggregator_top.sv -----
// Grid box aggregator top level: control sequencer, box update and result math.
// Depends on gba_pkg, gba_box_mem and gba_div.
//
// Usage: cells arrive in raster order on the in_valid/in_ready request
// channel (cell_value, cell_valid, cell_area). Each kernel x kernel box is
// reduced to one result on the out_valid/out_ready channel, issued with the
// bottom right cell of the box. Registers are written through cfg_wr_en,
// cfg_addr and cfg_wr_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Each cell is accepted,
// read from memory and read-modify-written before the next one is taken.
// The first cell after a register write re-derives the box column and box
// count with the 15-bit divider. A box whose average or sum needs a
// division uses the 96-bit serial divider; min, max and missing boxes skip it.
// Reset: registers return to kernel 2, average, area weight, 1024 columns;
// the box memory is then swept to zero with in_ready low.
// Stall: one finished result waits in the output register while the next
// cell is taken; a second result holds the sequencer until the first leaves.
module grid_box_aggregator_top #(
    parameter int MAX_OUT_COLUMNS = gba_pkg::DEF_MAX_OUT_COLUMNS,
    parameter int MAX_KERNEL      = gba_pkg::DEF_MAX_KERNEL
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [14:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] cell_value,
    input  logic               cell_valid,
    input  logic [15:0]        cell_area,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] box_result,
    output logic               box_present,
    output logic [9:0]         out_column,
    output logic               row_end
);
    import gba_pkg::*;

    localparam int AW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;

    gba_state_t state_reg, state_next;

    logic [4:0]  ks_reg;
    logic [1:0]  method_reg;
    logic        wm_reg;
    logic [14:0] cols_reg;
    logic        dirty_reg;

    logic [13:0] cnt_reg;
    logic [4:0]  phase_reg;
    logic [4:0]  sub_reg;
    logic [13:0] bc_reg;
    logic [14:0] nbox_reg;

    logic signed [31:0] val_reg;
    logic               vld_reg;
    logic [15:0]        area_reg;
    logic signed [48:0] prod_reg;

    box_entry_t ent_reg;
    logic [9:0]  col_out_reg;
    logic        row_end_reg;
    logic [31:0] m_reg;
    logic [47:0] d_reg;
    logic [63:0] mag_reg;
    logic        neg_reg;
    logic [63:0] p0_reg;
    logic [63:0] p1_reg;
    logic signed [63:0] res_reg;

    logic               out_valid_reg;
    logic signed [63:0] out_res_reg;
    logic               out_present_reg;
    logic [9:0]         out_col_reg;
    logic               out_end_reg;

    logic [4:0]  kk;
    logic [14:0] cols_eff;
    logic [13:0] col_eff;
    logic [4:0]  phase_eff;
    logic        inbox;
    logic        emit;
    logic        is_minmax;
    box_entry_t  rd_data;
    box_entry_t  ne;
    logic [31:0] w;
    logic [63:0] add64;
    logic [64:0] sum65;
    logic [31:0] tot;
    logic        out_load;

    logic        mem_rd_en;
    logic        mem_wr_en;
    box_entry_t  mem_wr_data;
    logic        clear_busy;

    logic        sdiv_start;
    logic [14:0] sdiv_dividend;
    logic        sdiv_done;
    logic [14:0] sdiv_q;
    logic [4:0]  sdiv_r;

    logic        bdiv_start;
    logic [95:0] bdiv_dividend;
    logic        bdiv_done;
    logic [95:0] bdiv_q;
    logic        over;

    always_comb
    begin
        if (ks_reg == 5'd0)
        begin
            kk = 5'd1;
        end
        else if (32'(ks_reg) > MAX_KERNEL)
        begin
            kk = 5'(MAX_KERNEL);
        end
        else
        begin
            kk = ks_reg;
        end
        if (cols_reg == 15'd0)
        begin
            cols_eff = 15'd1;
        end
        else if (cols_reg > COLUMN_LIMIT)
        begin
            cols_eff = COLUMN_LIMIT;
        end
        else
        begin
            cols_eff = cols_reg;
        end
        col_eff   = ({1'b0, cnt_reg} >= cols_eff) ? 14'd0 : cnt_reg;
        phase_eff = (phase_reg >= kk) ? 5'd0 : phase_reg;
        is_minmax = (method_reg == METH_MIN) || (method_reg == METH_MAX);
        inbox     = ({1'b0, bc_reg} < nbox_reg) &&
                    (32'(bc_reg) < MAX_OUT_COLUMNS);
        emit      = inbox && (sub_reg == kk - 5'd1) && (phase_eff == kk - 5'd1);
        tot       = sat_add32(ent_reg.pw, ent_reg.mw);
        out_load  = !out_valid_reg || out_ready;
        over      = |bdiv_q[95:63];
    end

    // box update
    always_comb
    begin
        w     = wm_reg ? 32'd1 : {16'd0, area_reg};
        add64 = wm_reg ? {{32{val_reg[31]}}, val_reg} : {{15{prod_reg[48]}}, prod_reg};
        sum65 = {rd_data.acc[63], rd_data.acc} + {add64[63], add64};
        ne    = rd_data;
        if (!vld_reg)
        begin
            ne.mw = sat_add32(rd_data.mw, w);
        end
        else if (is_minmax)
        begin
            if (!rd_data.seen ||
                ((method_reg == METH_MIN) ? ($signed({{32{val_reg[31]}}, val_reg}) < rd_data.acc)
                                          : ($signed({{32{val_reg[31]}}, val_reg}) > rd_data.acc)))
            begin
                ne.acc = {{32{val_reg[31]}}, val_reg};
            end
            ne.pw   = sat_add32(rd_data.pw, 32'd1);
            ne.seen = 1'b1;
        end
        else
        begin
            if (sum65[64] != sum65[63])
            begin
                ne.acc = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                ne.acc = sum65[63:0];
            end
            ne.pw   = sat_add32(rd_data.pw, w);
            ne.seen = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !clear_busy)
                begin
                    state_next = dirty_reg ? ST_SYNC_COL : ST_READ;
                end
            end
            ST_SYNC_COL: state_next = ST_WAIT_COL;
            ST_WAIT_COL: state_next = sdiv_done ? ST_SYNC_NB : ST_WAIT_COL;
            ST_SYNC_NB:  state_next = ST_WAIT_NB;
            ST_WAIT_NB:  state_next = sdiv_done ? ST_READ : ST_WAIT_NB;
            ST_READ:     state_next = ST_UPDATE;
            ST_UPDATE:   state_next = emit ? ST_PREP : ST_IDLE;
            ST_PREP:
            begin
                if (!ent_reg.seen || is_minmax || ent_reg.pw == 32'd0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: state_next = bdiv_done ? ST_FINISH : ST_DIV_WAIT;
            ST_FINISH:   state_next = out_load ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE) && !clear_busy;
        sdiv_start    = (state_reg == ST_SYNC_COL) || (state_reg == ST_SYNC_NB);
        sdiv_dividend = (state_reg == ST_SYNC_COL) ? {1'b0, col_eff} : cols_eff;
        bdiv_start    = (state_reg == ST_DIV_GO);
        bdiv_dividend = {32'd0, p0_reg} + {p1_reg, 32'd0};
        mem_rd_en     = (state_reg == ST_READ);
        mem_wr_en     = (state_reg == ST_UPDATE) && inbox;
        mem_wr_data   = emit ? '0 : ne;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ks_reg        <= 5'd2;
            method_reg    <= METH_AVG;
            wm_reg        <= 1'b0;
            cols_reg      <= 15'd1024;
            dirty_reg     <= 1'b1;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            sub_reg       <= '0;
            bc_reg        <= '0;
            nbox_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WAIT_NB && sdiv_done)
            begin
                dirty_reg <= 1'b0;
                nbox_reg  <= sdiv_q;
            end
            if (cfg_wr_en)
            begin
                dirty_reg <= 1'b1;
                unique case (cfg_addr)
                    REG_KERNEL_SIZE: ks_reg     <= cfg_wr_data[4:0];
                    REG_METHOD:      method_reg <= cfg_wr_data[1:0];
                    REG_WEIGHT_MODE: wm_reg     <= cfg_wr_data[0];
                    REG_IN_COLUMNS:  cols_reg   <= cfg_wr_data;
                    default:         ;
                endcase
            end
            if (state_reg == ST_WAIT_COL && sdiv_done)
            begin
                cnt_reg <= col_eff;
                bc_reg  <= sdiv_q[13:0];
                sub_reg <= sdiv_r;
            end
            if (state_reg == ST_UPDATE)
            begin
                if ({1'b0, col_eff} + 15'd1 >= cols_eff)
                begin
                    cnt_reg   <= '0;
                    sub_reg   <= '0;
                    bc_reg    <= '0;
                    phase_reg <= (phase_eff + 5'd1 >= kk) ? 5'd0 : phase_eff + 5'd1;
                end
                else
                begin
                    cnt_reg   <= col_eff + 14'd1;
                    phase_reg <= phase_eff;
                    if (sub_reg == kk - 5'd1)
                    begin
                        sub_reg <= '0;
                        bc_reg  <= bc_reg + 14'd1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 5'd1;
                    end
                end
            end
            if (state_reg == ST_FINISH && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            val_reg  <= cell_value;
            vld_reg  <= cell_valid;
            area_reg <= cell_area;
        end
        if (state_reg == ST_READ)
        begin
            prod_reg <= val_reg * $signed({1'b0, area_reg});
        end
        if (state_reg == ST_UPDATE)
        begin
            ent_reg     <= ne;
            col_out_reg <= bc_reg[9:0];
            row_end_reg <= ({1'b0, bc_reg} == nbox_reg - 15'd1);
        end
        if (state_reg == ST_PREP)
        begin
            res_reg <= (ent_reg.seen && is_minmax) ? ent_reg.acc : 64'sd0;
            neg_reg <= ent_reg.acc[63];
            mag_reg <= ent_reg.acc[63] ? 64'd0 - ent_reg.acc : ent_reg.acc;
            if (method_reg == METH_SUM)
            begin
                m_reg <= tot;
                d_reg <= wm_reg ? {16'd0, ent_reg.pw} : {ent_reg.pw, 16'd0};
            end
            else
            begin
                m_reg <= 32'd1;
                d_reg <= {16'd0, ent_reg.pw};
            end
        end
        if (state_reg == ST_MUL_LO)
        begin
            p0_reg <= mag_reg[31:0] * m_reg;
        end
        if (state_reg == ST_MUL_HI)
        begin
            p1_reg <= mag_reg[63:32] * m_reg;
        end
        if (state_reg == ST_DIV_WAIT && bdiv_done)
        begin
            if (neg_reg)
            begin
                res_reg <= over ? {1'b1, 63'd0} : 64'd0 - bdiv_q[63:0];
            end
            else
            begin
                res_reg <= over ? {1'b0, {63{1'b1}}} : bdiv_q[63:0];
            end
        end
        if (state_reg == ST_FINISH && out_load)
        begin
            out_res_reg     <= res_reg;
            out_present_reg <= ent_reg.seen;
            out_col_reg     <= col_out_reg;
            out_end_reg     <= row_end_reg;
        end
    end

    gba_box_mem #(
        .DEPTH (MAX_OUT_COLUMNS),
        .AW    (AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (mem_rd_en),
        .rd_addr    (bc_reg[AW-1:0]),
        .rd_data    (rd_data),
        .wr_en      (mem_wr_en),
        .wr_addr    (bc_reg[AW-1:0]),
        .wr_data    (mem_wr_data),
        .clear_busy (clear_busy)
    );

    gba_div #(
        .NW (15),
        .DW (5)
    ) u_idx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sdiv_start),
        .dividend  (sdiv_dividend),
        .divisor   (kk),
        .done      (sdiv_done),
        .quotient  (sdiv_q),
        .remainder (sdiv_r)
    );

    gba_div #(
        .NW (96),
        .DW (48)
    ) u_res_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (bdiv_start),
        .dividend  (bdiv_dividend),
        .divisor   (d_reg),
        .done      (bdiv_done),
        .quotient  (bdiv_q),
        .remainder ()
    );

    assign out_valid   = out_valid_reg;
    assign box_result  = out_res_reg;
    assign box_present = out_present_reg;
    assign out_column  = out_col_reg;
    assign row_end     = out_end_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_missing_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !box_present |-> box_result == 64'sd0)
        else $error("missing box with nonzero result");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> state_reg == ST_UPDATE && !clear_busy)
        else $error("box memory written outside update");

    a_div_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_WAIT && bdiv_done |=> state_reg == ST_FINISH)
        else $error("divider result dropped");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Testbench for grid_box_aggregator_top: directed and random raster cells against a box-aggregation predictor.
// Depends on gba_pkg and the grid_box_aggregator_top RTL.
`timescale 1ns / 1ps

module tb_top;
    import gba_pkg::*;

    typedef struct {
        longint     result;
        bit         present;
        bit [9:0]   column;
        bit         last_box;
    } box_exp_t;

    class box_scoreboard;
        bit [4:0]  ksize;
        bit [1:0]  meth;
        bit        by_count;
        bit [14:0] ncols;
        int unsigned col_cnt, row_ph;
        longint    acc[1024];
        bit [31:0] pw[1024];
        bit [31:0] mw[1024];
        bit        seen[1024];
        box_exp_t  pending[$];
        int        errors;
        int        boxes_seen;

        function new();
            ksize = 2;
            meth = METH_AVG;
            by_count = 0;
            ncols = 15'd1024;
            col_cnt = 0;
            row_ph = 0;
            errors = 0;
            boxes_seen = 0;
            for (int c = 0; c < 1024; c++)
            begin
                clear(c);
            end
        endfunction

        function void clear(int c);
            acc[c] = 0;
            pw[c] = 0;
            mw[c] = 0;
            seen[c] = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [14:0] val);
            case (idx)
                REG_KERNEL_SIZE: ksize = val[4:0];
                REG_METHOD:      meth = val[1:0];
                REG_WEIGHT_MODE: by_count = val[0];
                REG_IN_COLUMNS:  ncols = val;
            endcase
        endfunction

        function bit [31:0] wsat(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function longint asat(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            return s;
        endfunction

        function longint scale_div(longint a, bit [31:0] m, bit [63:0] d);
            bit         neg;
            bit [63:0]  mag;
            bit [127:0] q;
            neg = a < 0;
            mag = neg ? -a : a;
            q = ({64'b0, mag} * {96'b0, m}) / {64'b0, d};
            if (neg)
            begin
                if (q > 128'h8000_0000_0000_0000)
                    q = 128'h8000_0000_0000_0000;
                return -q[63:0];
            end
            if (q > 128'h7FFF_FFFF_FFFF_FFFF)
                q = 128'h7FFF_FFFF_FFFF_FFFF;
            return q[63:0];
        endfunction

        function void note_cell(logic signed [31:0] val, logic ok, logic [15:0] area);
            int unsigned k, cols, col, ph, bc, nbox;
            bit [31:0]   w;
            bit [31:0]   tot;
            longint      v, res;
            box_exp_t    e;
            k = (ksize == 0) ? 1 : ksize;
            if (k > 16) k = 16;
            cols = (ncols == 0) ? 1 : ncols;
            if (cols > 16384) cols = 16384;
            v = val;
            col = (col_cnt >= cols) ? 0 : col_cnt;
            ph = (row_ph >= k) ? 0 : row_ph;
            bc = col / k;
            nbox = cols / k;
            if (bc < nbox && bc < 1024)
            begin
                w = by_count ? 1 : area;
                if (!ok)
                    mw[bc] = wsat(mw[bc], w);
                else if (meth == METH_MIN || meth == METH_MAX)
                begin
                    if (!seen[bc] || (meth == METH_MIN ? v < acc[bc] : v > acc[bc]))
                        acc[bc] = v;
                    pw[bc] = wsat(pw[bc], 1);
                    seen[bc] = 1;
                end
                else
                begin
                    acc[bc] = asat(acc[bc], by_count ? v : v * longint'({48'b0, area}));
                    pw[bc] = wsat(pw[bc], w);
                    seen[bc] = 1;
                end
                if (col % k == k - 1 && ph == k - 1)
                begin
                    res = 0;
                    if (seen[bc])
                    begin
                        if (meth == METH_MIN || meth == METH_MAX)
                            res = acc[bc];
                        else if (pw[bc] != 0)
                        begin
                            if (meth == METH_AVG)
                                res = scale_div(acc[bc], 1, {32'b0, pw[bc]});
                            else
                            begin
                                tot = wsat(pw[bc], mw[bc]);
                                res = scale_div(acc[bc], tot,
                                    by_count ? {32'b0, pw[bc]} : {16'b0, pw[bc], 16'b0});
                            end
                        end
                    end
                    e.result = res;
                    e.present = seen[bc];
                    e.column = bc[9:0];
                    e.last_box = (bc == nbox - 1);
                    pending.push_back(e);
                    clear(bc);
                end
            end
            col++;
            if (col >= cols)
            begin
                col = 0;
                ph++;
                if (ph >= k) ph = 0;
            end
            col_cnt = col;
            row_ph = ph;
        endfunction

        function void check_box(longint res, bit pres, bit [9:0] column, bit rend);
            box_exp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected box result %0d", res);
                errors++;
                return;
            end
            e = pending.pop_front();
            boxes_seen++;
            if (res != e.result)
            begin
                $error("box_result expected %0d actual %0d", e.result, res);
                errors++;
            end
            if (pres != e.present)
            begin
                $error("box_present expected %0d actual %0d", e.present, pres);
                errors++;
            end
            if (column != e.column)
            begin
                $error("out_column expected %0d actual %0d", e.column, column);
                errors++;
            end
            if (rend != e.last_box)
            begin
                $error("row_end expected %0d actual %0d", e.last_box, rend);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_wr_en = 0;
    logic [1:0]         cfg_addr = '0;
    logic [14:0]        cfg_wr_data = '0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] cell_value = '0;
    logic               cell_valid = 0;
    logic [15:0]        cell_area = '0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [63:0] box_result;
    logic               box_present;
    logic [9:0]         out_column;
    logic               row_end;

    box_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  cells_sent = 0;

    grid_box_aggregator_top dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_cell(cell_value, cell_valid, cell_area);
            if (out_valid && out_ready)
                sb.check_box(box_result, box_present, out_column, row_end);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000)
            begin
                $display("watchdog: no progress in %0d cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(bit [1:0] idx, bit [14:0] val);
        @(negedge clk);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    task automatic send_cell(logic signed [31:0] v, logic ok, logic [15:0] a);
        int gap;
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        cell_value <= v;
        cell_valid <= ok;
        cell_area <= a;
        do @(posedge clk); while (!in_ready);
        cells_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic configure(bit [4:0] k, bit [1:0] m, bit wm, bit [14:0] cols);
        drain();
        write_reg(REG_KERNEL_SIZE, {10'b0, k});
        write_reg(REG_METHOD, {13'b0, m});
        write_reg(REG_WEIGHT_MODE, {14'b0, wm});
        write_reg(REG_IN_COLUMNS, cols);
    endtask

    task automatic send_random_cell();
        logic signed [31:0] v;
        logic [15:0]        a;
        case ($urandom_range(9))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = 0;
            default: v = $urandom;
        endcase
        case ($urandom_range(7))
            0: a = 0;
            1: a = 16'hFFFF;
            default: a = 16'($urandom);
        endcase
        send_cell(v, $urandom_range(9) != 0, a);
    endtask

    initial
    begin
        int k, nb, cnt;
        repeat (2) @(negedge clk);
        rst_n <= 1;

        // directed: single-cell boxes with extreme values, every method
        configure(1, METH_AVG, 0, 1);
        send_cell(32'sh7FFF_FFFF, 1, 16'hFFFF);
        send_cell(32'sh8000_0000, 1, 16'h0001);
        send_cell(32'sh0001_0000, 1, 16'h0000);
        send_cell(32'sh0001_0000, 0, 16'hFFFF);
        configure(1, METH_MIN, 1, 1);
        send_cell(32'sh8000_0000, 1, 16'h1234);
        send_cell(32'sh7FFF_FFFF, 0, 16'h0);
        configure(1, METH_MAX, 0, 1);
        send_cell(32'sh7FFF_FFFF, 1, 16'h0);
        send_cell(-32'sd5, 1, 16'hFFFF);
        configure(1, METH_SUM, 0, 1);
        send_cell(32'sh7FFF_FFFF, 1, 16'hFFFF);
        send_cell(32'sh8000_0000, 1, 16'h0);
        // box with one present cell of weight 1 and a large missing weight
        configure(2, METH_SUM, 0, 2);
        send_cell(32'sh8000_0000, 1, 16'h0001);
        send_cell(32'sh0, 0, 16'hFFFF);
        send_cell(32'sh0, 0, 16'hFFFF);
        send_cell(32'sh0, 0, 16'hFFFF);
        // leftover column, zero kernel, oversize kernel and column count
        configure(2, METH_SUM, 1, 5);
        repeat (10) send_random_cell();
        configure(0, METH_AVG, 1, 0);
        repeat (3) send_random_cell();
        configure(31, METH_MAX, 0, 15'h7FFF);
        repeat (4) send_random_cell();
        // method changed mid box
        configure(2, METH_AVG, 0, 2);
        repeat (2) send_random_cell();
        configure(2, METH_MIN, 0, 2);
        repeat (2) send_random_cell();

        // random phases
        for (int p = 0; p < 16; p++)
        begin
            k = (p == 9) ? 16 : $urandom_range(1, 4);
            nb = $urandom_range(1, 6);
            configure(k[4:0], 2'($urandom_range(3)), 1'($urandom_range(1)),
                15'(k * nb + (($urandom_range(3) == 0) ? 1 : 0)));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (p == 4)
                hold_req = 1;
            cnt = (p == 9) ? 260 : 36;
            repeat (cnt) send_random_cell();
        end

        drain();
        $display("Sent %0d cells over all methods, weight modes and kernel sizes 0 to 31;",
            cells_sent);
        $display("checked %0d box results under idle, stall and hold-off phases.",
            sb.boxes_seen);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
